// ----- rtl/core/tfi_pkg.sv -----
// Package for the translation buffer fill and invalidate block.
// Holds sizes, command and event codes, and the controller/datapath links.
// No dependencies.
package tfi_pkg;

    // Buffer size and derived index width.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int PAGE_W  = 20;
    localparam int PID_W   = 15;
    localparam int SLOT_W  = 6;
    localparam int CMD_W   = 2;
    localparam int EV_W    = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INVAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    // Event codes reported with each result.
    localparam logic [EV_W-1:0] EV_FILL_FREE    = 3'd0;
    localparam logic [EV_W-1:0] EV_FILL_REPLACE = 3'd1;
    localparam logic [EV_W-1:0] EV_INVALIDATED  = 3'd2;
    localparam logic [EV_W-1:0] EV_ABSENT       = 3'd3;
    localparam logic [EV_W-1:0] EV_FLUSHED      = 3'd4;
    localparam logic [EV_W-1:0] EV_SKIPPED      = 3'd5;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic commit;
    } tfi_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic req_is_op;
        logic out_free;
    } tfi_status_t;

    // Map a slot index onto the result's slot field (low bits, zero padded).
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/tfi_ctrl.sv -----
// Controller for the translation buffer: accepts a request and, for a real command, then commits it.
// Depends on tfi_pkg.
module tfi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tfi_pkg::tfi_status_t status,
    output tfi_pkg::tfi_cmd_t    cmd
);
    import tfi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take_req;
    logic   commit_req;

    // A request is taken only in the idle state.
    assign req_ready = (state_reg == S_IDLE);
    assign take_req  = req_valid && req_ready;

    // Both strobes leave through one command bundle.
    assign cmd = '{capture: take_req, commit: commit_req};

    // Next state and commit strobe.
    always_comb
    begin
        state_next = state_reg;
        commit_req = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_req && status.req_is_op)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    commit_req = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/tfi_datapath.sv -----
// Datapath for the translation buffer: entry storage, page match, fill
// pointer, freed slot and the result register. Depends on tfi_pkg.
module tfi_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tfi_pkg::tfi_cmd_t             cmd,
    output tfi_pkg::tfi_status_t          status,
    input  logic [tfi_pkg::CMD_W-1:0]     command,
    input  logic [tfi_pkg::PID_W-1:0]     process_id,
    input  logic [tfi_pkg::PAGE_W-1:0]    virtual_page,
    input  logic [tfi_pkg::PAGE_W-1:0]    physical_page,
    input  logic                          writable,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [tfi_pkg::SLOT_W-1:0]    slot,
    output logic [tfi_pkg::EV_W-1:0]      event_res
);
    import tfi_pkg::*;

    // Entry storage: virtual pages feed one comparator each.
    logic [PAGE_W-1:0] vpage_reg [ENTRIES];
    logic [PAGE_W-1:0] ppage_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;

    // Request captured at accept.
    logic [CMD_W-1:0]  req_cmd_reg;
    logic [PID_W-1:0]  req_pid_reg;
    logic [PAGE_W-1:0] req_vpage_reg;
    logic [PAGE_W-1:0] req_ppage_reg;
    logic              req_wr_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_now;

    // Replacement state.
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             all_used_reg, all_used_next;
    logic             freed_held_reg, freed_held_next;
    logic [IDX_W-1:0] freed_slot_reg, freed_slot_next;
    logic [PID_W-1:0] last_pid_reg, last_pid_next;

    // Result register.
    logic              rsp_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [EV_W-1:0]   event_reg;

    // Commit-cycle signals.
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] res_idx;
    logic [EV_W-1:0]  res_event;

    assign status.req_is_op = (command == CMD_FILL) || (command == CMD_INVAL)
                              || (command == CMD_FLUSH);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    // Compare the incoming page against every valid entry.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_now[i] = valid_reg[i] && (vpage_reg[i] == virtual_page);
        end
    end

    // Lowest matching entry.
    always_comb
    begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Capture the request and its match vector.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_cmd_reg   <= command;
            req_pid_reg   <= process_id;
            req_vpage_reg <= virtual_page;
            req_ppage_reg <= physical_page;
            req_wr_reg    <= writable;
            match_reg     <= match_now;
        end
    end

    // Update of the buffer state when a request commits.
    always_comb
    begin
        ptr_next        = ptr_reg;
        all_used_next   = all_used_reg;
        freed_held_next = freed_held_reg;
        freed_slot_next = freed_slot_reg;
        last_pid_next   = last_pid_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        wr_en           = 1'b0;
        wr_idx          = ptr_reg;
        res_idx         = '0;
        res_event       = EV_ABSENT;
        if (cmd.commit)
        begin
            case (req_cmd_reg)
                CMD_FILL:
                begin
                    last_pid_next = req_pid_reg;
                    res_event     = all_used_reg ? EV_FILL_REPLACE : EV_FILL_FREE;
                    if (freed_held_reg)
                    begin
                        wr_idx          = freed_slot_reg;
                        freed_held_next = 1'b0;
                    end
                    else if (ptr_reg == LAST_IDX)
                    begin
                        ptr_next      = '0;
                        all_used_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                    wr_en              = 1'b1;
                    valid_next[wr_idx] = 1'b1;
                    dirty_next[wr_idx] = req_wr_reg;
                    res_idx            = wr_idx;
                end
                CMD_INVAL:
                begin
                    if (|match_reg)
                    begin
                        valid_next[hit_idx] = 1'b0;
                        dirty_next[hit_idx] = 1'b0;
                        freed_held_next     = 1'b1;
                        freed_slot_next     = hit_idx;
                        res_idx             = hit_idx;
                        res_event           = EV_INVALIDATED;
                    end
                end
                CMD_FLUSH:
                begin
                    if (req_pid_reg == last_pid_reg)
                    begin
                        res_event = EV_SKIPPED;
                    end
                    else
                    begin
                        valid_next      = '0;
                        dirty_next      = '0;
                        freed_held_next = 1'b0;
                        freed_slot_next = '0;
                        ptr_next        = '0;
                        all_used_next   = 1'b0;
                        last_pid_next   = '0;
                        res_event       = EV_FLUSHED;
                    end
                end
                default:
                begin
                    res_event = EV_ABSENT;
                end
            endcase
        end
    end

    // Entry payload writes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vpage_reg[wr_idx] <= req_vpage_reg;
            ppage_mem[wr_idx] <= req_ppage_reg;
        end
    end

    // Control state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            dirty_reg      <= '0;
            ptr_reg        <= '0;
            all_used_reg   <= 1'b0;
            freed_held_reg <= 1'b0;
            freed_slot_reg <= '0;
            last_pid_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            ptr_reg        <= ptr_next;
            all_used_reg   <= all_used_next;
            freed_held_reg <= freed_held_next;
            freed_slot_reg <= freed_slot_next;
            last_pid_reg   <= last_pid_next;
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_reg  <= to_slot(res_idx);
            event_reg <= res_event;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign slot      = slot_reg;
    assign event_res = event_reg;

endmodule

// ----- rtl/core/tlb_fill_and_invalidate.sv -----
// A request and its match vector are captured at accept; its result is registered
// when it commits, which waits while an earlier result is stalled at the output.
// A new request is taken only after the current one commits; the priority pick and
// state update use the registered match vector in the commit state.
// Unused command code 3 is taken while staying idle and gives no result.
// Reset is asynchronous, active low, and clears all valid bits at once.
// Top level of the translation buffer; depends on tfi_pkg, tfi_ctrl, tfi_datapath.
module tlb_fill_and_invalidate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [tfi_pkg::CMD_W-1:0]     command,
    input  logic [tfi_pkg::PID_W-1:0]     process_id,
    input  logic [tfi_pkg::PAGE_W-1:0]    virtual_page,
    input  logic [tfi_pkg::PAGE_W-1:0]    physical_page,
    input  logic                          writable,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [tfi_pkg::SLOT_W-1:0]    slot,
    output logic [tfi_pkg::EV_W-1:0]      event_res
);
    import tfi_pkg::*;

    tfi_cmd_t    cmd;
    tfi_status_t status;

    // Sequencing of each request.
    tfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage, match and replacement logic.
    tfi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .process_id    (process_id),
        .virtual_page  (virtual_page),
        .physical_page (physical_page),
        .writable      (writable),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .slot          (slot),
        .event_res     (event_res)
    );

endmodule

// ----- rtl/core/tfi_checker.sv -----
// Port-level checks for the translation buffer, bound to the top level.
// Depends on tfi_pkg.
module tfi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [tfi_pkg::CMD_W-1:0]     command,
    input logic [tfi_pkg::PID_W-1:0]     process_id,
    input logic [tfi_pkg::PAGE_W-1:0]    virtual_page,
    input logic [tfi_pkg::PAGE_W-1:0]    physical_page,
    input logic                          writable,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [tfi_pkg::SLOT_W-1:0]    slot,
    input logic [tfi_pkg::EV_W-1:0]      event_res
);
    import tfi_pkg::*;

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot) && $stable(event_res))
        else $error("result changed while stalled");

    // A real command keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready
        && (command == CMD_FILL || command == CMD_INVAL || command == CMD_FLUSH)
        |=> !req_ready)
        else $error("request taken while previous one in flight");

    // Results without a slot report slot zero.
    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (event_res == EV_ABSENT || event_res == EV_FLUSHED
                      || event_res == EV_SKIPPED) |-> slot == '0)
        else $error("nonzero slot on slotless event");

    // A new result only appears after a busy cycle.
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a commit cycle");

endmodule

bind tlb_fill_and_invalidate tfi_checker u_checker (.*);

// ----- tb/tlb_fill_and_invalidate_test.sv -----
// Self-checking testbench for the translation buffer fill and invalidate block.
// Holds a shadow copy of the buffer that predicts every response; depends on
// tfi_pkg and tlb_fill_and_invalidate.
module tlb_fill_and_invalidate_test;
    import tfi_pkg::*;

    // The one command code the block takes but never answers.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_PHASE = 363;
    localparam int TAIL_CYCLES   = 8;
    localparam int RECENT_DEPTH  = 24;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [EV_W-1:0]   ev;
    } tlb_result_t;

    // Shadow copy of the buffer: predicts the response of every accepted
    // request and checks the block's responses against them in order.
    class tlb_mirror;
        logic [PAGE_W-1:0] vpage_tbl [ENTRIES];
        logic [PAGE_W-1:0] ppage_tbl [ENTRIES];
        bit                valid_tbl [ENTRIES];
        bit                dirty_tbl [ENTRIES];
        int unsigned       next_fill;
        bit                wrapped;
        bit                freed_held;
        int unsigned       freed_idx;
        logic [PID_W-1:0]  last_pid;
        tlb_result_t       pending_results [$];
        int unsigned       error_count;

        function new();
            clear_table();
            last_pid    = '0;
            error_count = 0;
        endfunction

        // Empties every slot and brings the fill pointer back to the start.
        function void clear_table();
            for (int i = 0; i < ENTRIES; i++)
            begin
                vpage_tbl[i] = '0;
                ppage_tbl[i] = '0;
                valid_tbl[i] = 1'b0;
                dirty_tbl[i] = 1'b0;
            end
            next_fill  = 0;
            wrapped    = 1'b0;
            freed_held = 1'b0;
            freed_idx  = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Applies one accepted request and queues the response it must give.
        function void note_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                   logic [PAGE_W-1:0] vpage, logic [PAGE_W-1:0] ppage,
                                   logic wr);
            tlb_result_t res;
            int unsigned idx;
            bit          hit;
            res = '0;
            hit = 1'b0;
            case (cmd)
                CMD_FILL:
                begin
                    last_pid = pid;
                    res.ev   = wrapped ? EV_FILL_REPLACE : EV_FILL_FREE;
                    // A slot freed by the last invalidation wins over the pointer.
                    if (freed_held && freed_idx < ENTRIES)
                    begin
                        idx        = freed_idx;
                        freed_held = 1'b0;
                    end
                    else
                    begin
                        freed_held = 1'b0;
                        idx        = next_fill;
                        if (idx + 1 >= ENTRIES)
                        begin
                            next_fill = 0;
                            wrapped   = 1'b1;
                        end
                        else
                        begin
                            next_fill = idx + 1;
                        end
                    end
                    vpage_tbl[idx] = vpage;
                    ppage_tbl[idx] = ppage;
                    valid_tbl[idx] = 1'b1;
                    dirty_tbl[idx] = wr;
                    res.slot       = SLOT_W'(idx);
                    pending_results.push_back(res);
                end
                CMD_INVAL:
                begin
                    // Only the lowest valid match is cleared.
                    for (int i = 0; i < ENTRIES && !hit; i++)
                    begin
                        if (valid_tbl[i] && vpage_tbl[i] == vpage)
                        begin
                            hit          = 1'b1;
                            valid_tbl[i] = 1'b0;
                            dirty_tbl[i] = 1'b0;
                            freed_held   = 1'b1;
                            freed_idx    = i;
                            res.slot     = SLOT_W'(i);
                        end
                    end
                    res.ev = hit ? EV_INVALIDATED : EV_ABSENT;
                    pending_results.push_back(res);
                end
                CMD_FLUSH:
                begin
                    // A flush from the process that filled last is skipped.
                    if (pid == last_pid)
                    begin
                        res.ev = EV_SKIPPED;
                    end
                    else
                    begin
                        clear_table();
                        last_pid = '0;
                        res.ev   = EV_FLUSHED;
                    end
                    pending_results.push_back(res);
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compares one accepted response with the oldest prediction.
        function void check_response(logic [SLOT_W-1:0] got_slot, logic [EV_W-1:0] got_ev);
            tlb_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("response with no pending request: slot %0d event_res %0d",
                       got_slot, got_ev);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got_slot !== want.slot)
            begin
                $error("slot mismatch: expected %0d, actual %0d", want.slot, got_slot);
                error_count++;
            end
            if (got_ev !== want.ev)
            begin
                $error("event_res mismatch: expected %0d, actual %0d", want.ev, got_ev);
                error_count++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [CMD_W-1:0]   command = CMD_FILL;
    logic [PID_W-1:0]   process_id = '0;
    logic [PAGE_W-1:0]  virtual_page = '0;
    logic [PAGE_W-1:0]  physical_page = '0;
    logic               writable = 1'b0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [SLOT_W-1:0]  slot;
    logic [EV_W-1:0]    event_res;

    tlb_mirror          mirror;
    int                 src_idle_pct = 0;
    int                 sink_stall_pct = 0;
    int unsigned        cycle_count = 0;
    logic [PAGE_W-1:0]  recent_pages [$];
    logic [PID_W-1:0]   last_fill_pid = '0;

    tlb_fill_and_invalidate u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .command       (command),
        .process_id    (process_id),
        .virtual_page  (virtual_page),
        .physical_page (physical_page),
        .writable      (writable),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .slot          (slot),
        .event_res     (event_res)
    );

    // Clock with a 10 unit period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side back-pressure.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** tlb_fill_and_invalidate: FAILED **");
            $finish;
        end
    end

    // Check responses before noting requests taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                mirror.check_response(slot, event_res);
            end
            if (req_valid && req_ready)
            begin
                mirror.note_request(command, process_id, virtual_page,
                                    physical_page, writable);
            end
        end
    end

    // Presents one request, with random idle cycles ahead of it, and holds it
    // until the block takes it.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                logic [PAGE_W-1:0] vpage, logic [PAGE_W-1:0] ppage,
                                logic wr);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        command       <= cmd;
        process_id    <= pid;
        virtual_page  <= vpage;
        physical_page <= ppage;
        writable      <= wr;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
    endtask

    // Stops sending until every predicted response has come back.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Hand-picked requests: field extremes, duplicates, freed slots and flushes.
    task automatic run_directed();
        send_request(CMD_FLUSH,  15'h0000, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_FILL,   15'h7FFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
        send_request(CMD_FILL,   15'h0000, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_FILL,   15'h0001, 20'hFFFFF, 20'hAAAAA, 1'b1);
        send_request(CMD_INVAL,  15'h7FFF, 20'hFFFFF, 20'h00000, 1'b0);
        send_request(CMD_INVAL,  15'h0000, 20'hFFFFF, 20'hFFFFF, 1'b1);
        send_request(CMD_INVAL,  15'h2AAA, 20'h12345, 20'h00000, 1'b0);
        send_request(CMD_FILL,   15'h0003, 20'h55555, 20'h55555, 1'b0);
        send_request(CMD_UNUSED, 15'h7FFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
        send_request(CMD_FILL,   15'h0003, 20'h2AAAA, 20'h2AAAA, 1'b1);
        send_request(CMD_FLUSH,  15'h0003, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_FLUSH,  15'h7FFF, 20'hFFFFF, 20'hFFFFF, 1'b1);
        send_request(CMD_FLUSH,  15'h0000, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_INVAL,  15'h0000, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_UNUSED, 15'h0000, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_FILL,   15'h0000, 20'h00000, 20'h0F0F0, 1'b0);
        send_request(CMD_INVAL,  15'h5555, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_INVAL,  15'h0000, 20'h00000, 20'h00000, 1'b0);
        send_request(CMD_FILL,   15'h0000, 20'h00001, 20'hFFFFF, 1'b1);
        send_request(CMD_FILL,   15'h4000, 20'h80000, 20'h80000, 1'b0);
        last_fill_pid = 15'h4000;
    endtask

    // One random request, biased toward fills and invalidations of pages
    // that are likely resident, with flushes mostly from the last filler.
    task automatic send_random(output bit answered);
        int               pick;
        logic [PID_W-1:0] pid;
        logic [PAGE_W-1:0] vpage;
        pick     = $urandom_range(0, 99);
        answered = 1'b1;
        vpage    = PAGE_W'($urandom);
        pid      = ($urandom_range(0, 9) < 7) ? PID_W'($urandom_range(0, 3)) : PID_W'($urandom);
        if (pick < 58)
        begin
            if (recent_pages.size() != 0 && $urandom_range(0, 3) == 0)
            begin
                vpage = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            end
            recent_pages.push_back(vpage);
            if (recent_pages.size() > RECENT_DEPTH)
            begin
                void'(recent_pages.pop_front());
            end
            last_fill_pid = pid;
            send_request(CMD_FILL, pid, vpage, PAGE_W'($urandom), 1'($urandom));
        end
        else if (pick < 92)
        begin
            if (recent_pages.size() != 0 && $urandom_range(0, 99) < 85)
            begin
                vpage = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            end
            send_request(CMD_INVAL, PID_W'($urandom), vpage, PAGE_W'($urandom),
                         1'($urandom));
        end
        else if (pick < 97)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                pid = last_fill_pid;
            end
            if (pid != last_fill_pid)
            begin
                last_fill_pid = '0;
            end
            send_request(CMD_FLUSH, pid, vpage, PAGE_W'($urandom), 1'($urandom));
        end
        else
        begin
            answered = 1'b0;
            send_request(CMD_UNUSED, PID_W'($urandom), vpage, PAGE_W'($urandom),
                         1'($urandom));
        end
    endtask

    // Reset, directed part, then random phases under different idling.
    initial
    begin
        int sender_mix [4];
        int sink_mix   [4];
        int sent;
        bit answered;
        sender_mix = '{0, 57, 0, 26};
        sink_mix   = '{0, 0, 57, 26};
        mirror = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_responses();

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct   = sender_mix[p];
            sink_stall_pct = sink_mix[p];
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                send_random(answered);
                if (answered)
                begin
                    sent++;
                end
            end
            drain_responses();
        end

        // Let any trailing response show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.error_count == 0 && mirror.pending() == 0)
        begin
            $display("** tlb_fill_and_invalidate: PASSED **");
        end
        else
        begin
            if (mirror.pending() != 0)
            begin
                $error("%0d predicted responses never arrived", mirror.pending());
            end
            $display("** tlb_fill_and_invalidate: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tfi_pkg.sv
rtl/core/tfi_ctrl.sv
rtl/core/tfi_datapath.sv
rtl/core/tlb_fill_and_invalidate.sv
rtl/core/tfi_checker.sv
tb/tlb_fill_and_invalidate_test.sv
